// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("Assertion failed: same-cycle implication.");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("Assertion failed: next-cycle implication.");

`endif

// ===== rtl/ucf_pkg.sv =====
package ucf_pkg;

	localparam int PRESET_SLOTS = 4;
	localparam int SLOT_W = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;

	localparam logic [7:0] START_RESET    = 8'h30;
	localparam logic [7:0] END_RESET      = 8'h5A;
	localparam logic [6:0] DEADBAND_RESET = 7'd10;
	localparam logic [7:0] SLOT_BASE      = 8'h31;
	localparam logic [7:0] SERVO_RESET    = 8'd127;
	localparam logic [15:0] PRESET_ERASED = 16'hFFFF;

	localparam logic [15:0] OP_MOTOR_A = 16'h4141;
	localparam logic [15:0] OP_MOTOR_B = 16'h4242;
	localparam logic [15:0] OP_SERVO_X = 16'h4343;
	localparam logic [15:0] OP_SERVO_Y = 16'h4444;
	localparam logic [15:0] OP_RESTORE = 16'h4545;
	localparam logic [15:0] OP_SAVE    = 16'h4646;
	localparam logic [15:0] OP_MAN_ON  = 16'h4747;
	localparam logic [15:0] OP_MAN_OFF = 16'h4848;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_BACK = 2'd2;

	localparam logic [1:0] ST_NONE     = 2'd0;
	localparam logic [1:0] ST_DONE     = 2'd1;
	localparam logic [1:0] ST_BAD_OP   = 2'd2;
	localparam logic [1:0] ST_BAD_SLOT = 2'd3;

	localparam logic [1:0] REG_START    = 2'd0;
	localparam logic [1:0] REG_END      = 2'd1;
	localparam logic [1:0] REG_DEADBAND = 2'd2;

	typedef struct packed {
		logic        exec;
		logic [15:0] opcode;
		logic [7:0]  data;
	} ucf_cmd_t;

	typedef struct packed {
		logic [1:0] a_dir;
		logic [7:0] a_duty;
		logic [1:0] b_dir;
		logic [7:0] b_duty;
	} ucf_drive_t;

	typedef struct packed {
		logic [1:0] status;
		logic       preset_led;
		logic       remote_led;
		logic       manual_on;
		logic [7:0] servo_y_pulse;
		logic [7:0] servo_x_pulse;
		logic [7:0] motor_b_duty;
		logic [1:0] motor_b_dir;
		logic [7:0] motor_a_duty;
		logic [1:0] motor_a_dir;
	} ucf_result_t;

endpackage

// ===== rtl/ucf_frame_rx.sv =====
module ucf_frame_rx (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic            func,
	input  logic [7:0]      rx_byte,
	input  logic [7:0]      start_byte,
	input  logic [7:0]      end_byte,
	output ucf_pkg::ucf_cmd_t cmd
);
	import ucf_pkg::*;

	logic [1:0] idx_q;
	logic [7:0] bytes_q [3];
	logic       is_start;
	logic       is_end;
	logic       store;

	assign is_start = (rx_byte == start_byte);
	assign is_end   = (rx_byte == end_byte);
	assign store    = fire && !func && !is_start && !(is_end && idx_q == 2'd3) &&
		(idx_q != 2'd3);

	assign cmd.exec   = !func && !is_start && is_end && (idx_q == 2'd3);
	assign cmd.opcode = {bytes_q[0], bytes_q[1]};
	assign cmd.data   = bytes_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (fire && !func) begin
			if (is_start) begin
				idx_q <= 2'd0;
			end else if (store) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			bytes_q[idx_q] <= rx_byte;
		end
	end

endmodule

// ===== rtl/ucf_mixer.sv =====
module ucf_mixer (
	input  logic [7:0]          joy_fwd,
	input  logic [7:0]          joy_turn,
	input  logic [6:0]          deadband,
	output ucf_pkg::ucf_drive_t drive
);
	import ucf_pkg::*;

	logic signed [9:0] t;
	logic signed [9:0] r;
	logic signed [9:0] db;
	logic signed [9:0] sum_b;
	logic signed [9:0] mix_a;
	logic signed [9:0] mix_b;
	logic signed [9:0] neg_a;
	logic signed [9:0] neg_b;
	logic              in_band;

	// Only the sum can reach minus 256, so only that mix needs clamping.
	assign t     = $signed({2'b00, joy_fwd}) - 10'sd128;
	assign r     = $signed({2'b00, joy_turn}) - 10'sd128;
	assign db    = $signed({3'b000, deadband});
	assign sum_b = t + r;
	assign mix_a = t - r;
	assign mix_b = (sum_b < -10'sd255) ? -10'sd255 : sum_b;
	assign neg_a = -mix_a;
	assign neg_b = -mix_b;
	assign in_band = (t > -db) && (t < db) && (r > -db) && (r < db);

	always_comb begin
		if (in_band) begin
			drive.a_dir  = DIR_STOP;
			drive.a_duty = 8'd0;
			drive.b_dir  = DIR_STOP;
			drive.b_duty = 8'd0;
		end else begin
			drive.a_dir  = mix_a[9] ? DIR_BACK : DIR_FWD;
			drive.a_duty = mix_a[9] ? neg_a[7:0] : mix_a[7:0];
			drive.b_dir  = mix_b[9] ? DIR_BACK : DIR_FWD;
			drive.b_duty = mix_b[9] ? neg_b[7:0] : mix_b[7:0];
		end
	end

endmodule

// ===== rtl/ucf_state.sv =====
module ucf_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 func,
	input  ucf_pkg::ucf_cmd_t    cmd,
	input  ucf_pkg::ucf_drive_t  drive,
	input  logic [7:0]           joy_pan,
	input  logic [7:0]           joy_tilt,
	output ucf_pkg::ucf_result_t res
);
	import ucf_pkg::*;

	logic [1:0]  a_dir_q, b_dir_q;
	logic [7:0]  a_duty_q, b_duty_q;
	logic [7:0]  sx_q, sy_q, saved_x_q, saved_y_q;
	logic        manual_q, remote_q, preset_q;
	logic [15:0] store_q [PRESET_SLOTS];

	logic [7:0]  saved_x_n, saved_y_n;
	logic [7:0]  slot_diff;
	logic        slot_ok;
	logic [SLOT_W-1:0] slot;
	logic [15:0] slot_val;
	logic        save_en;
	logic [1:0]  srv_dir;
	logic [7:0]  srv_duty;

	assign slot_diff = cmd.data - SLOT_BASE;
	assign slot_ok   = (cmd.data >= SLOT_BASE) && (slot_diff < 8'(PRESET_SLOTS));
	assign slot      = slot_diff[SLOT_W-1:0];
	assign slot_val  = store_q[slot];

	always_comb begin
		if (cmd.data > 8'd127) begin
			srv_dir  = DIR_FWD;
			srv_duty = {1'b0, cmd.data[6:0]};
		end else if (cmd.data < 8'd127) begin
			srv_dir  = DIR_BACK;
			srv_duty = {1'b0, 7'h7F - cmd.data[6:0]};
		end else begin
			srv_dir  = DIR_STOP;
			srv_duty = 8'd0;
		end
	end

	always_comb begin
		res.motor_a_dir   = a_dir_q;
		res.motor_a_duty  = a_duty_q;
		res.motor_b_dir   = b_dir_q;
		res.motor_b_duty  = b_duty_q;
		res.servo_x_pulse = sx_q;
		res.servo_y_pulse = sy_q;
		res.manual_on     = manual_q;
		res.remote_led    = remote_q;
		res.preset_led    = preset_q;
		res.status        = ST_NONE;
		saved_x_n         = saved_x_q;
		saved_y_n         = saved_y_q;
		save_en           = 1'b0;
		if (func) begin
			if (manual_q) begin
				res.servo_x_pulse = joy_pan;
				res.servo_y_pulse = joy_tilt;
				res.motor_a_dir   = drive.a_dir;
				res.motor_a_duty  = drive.a_duty;
				res.motor_b_dir   = drive.b_dir;
				res.motor_b_duty  = drive.b_duty;
			end
		end else if (cmd.exec) begin
			res.preset_led = 1'b0;
			res.status     = ST_DONE;
			case (cmd.opcode)
				OP_MOTOR_A: begin
					res.motor_a_dir  = srv_dir;
					res.motor_a_duty = srv_duty;
				end
				OP_MOTOR_B: begin
					res.motor_b_dir  = srv_dir;
					res.motor_b_duty = srv_duty;
				end
				OP_SERVO_X: begin
					res.servo_x_pulse = cmd.data;
					saved_x_n         = cmd.data;
				end
				OP_SERVO_Y: begin
					res.servo_y_pulse = cmd.data;
					saved_y_n         = cmd.data;
				end
				OP_RESTORE: begin
					res.preset_led = 1'b1;
					if (slot_ok) begin
						res.servo_x_pulse = slot_val[15:8];
						res.servo_y_pulse = slot_val[7:0];
					end else begin
						res.status = ST_BAD_SLOT;
					end
				end
				OP_SAVE: begin
					res.preset_led = 1'b1;
					if (slot_ok) begin
						save_en = 1'b1;
					end else begin
						res.status = ST_BAD_SLOT;
					end
				end
				OP_MAN_ON: begin
					res.manual_on  = 1'b1;
					res.remote_led = 1'b0;
				end
				OP_MAN_OFF: begin
					res.manual_on  = 1'b0;
					res.remote_led = 1'b1;
				end
				default: begin
					res.status = ST_BAD_OP;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_dir_q   <= DIR_STOP;
			a_duty_q  <= 8'd0;
			b_dir_q   <= DIR_STOP;
			b_duty_q  <= 8'd0;
			sx_q      <= SERVO_RESET;
			sy_q      <= SERVO_RESET;
			saved_x_q <= 8'd0;
			saved_y_q <= 8'd0;
			manual_q  <= 1'b1;
			remote_q  <= 1'b0;
			preset_q  <= 1'b0;
			for (int i = 0; i < PRESET_SLOTS; i++) begin
				store_q[i] <= PRESET_ERASED;
			end
		end else if (fire) begin
			a_dir_q   <= res.motor_a_dir;
			a_duty_q  <= res.motor_a_duty;
			b_dir_q   <= res.motor_b_dir;
			b_duty_q  <= res.motor_b_duty;
			sx_q      <= res.servo_x_pulse;
			sy_q      <= res.servo_y_pulse;
			saved_x_q <= saved_x_n;
			saved_y_q <= saved_y_n;
			manual_q  <= res.manual_on;
			remote_q  <= res.remote_led;
			preset_q  <= res.preset_led;
			if (save_en) begin
				store_q[slot] <= {saved_x_q, saved_y_q};
			end
		end
	end

endmodule

// ===== rtl/uart_command_frame_motor_servo_ctrl_core.sv =====
// Serial command frame and joystick controller for two drive motors and a pan and tilt
// servo pair. Each request on the slave stream is either a received serial byte (tuser 0)
// or a joystick sample (tuser 1), and produces exactly one result on the master stream,
// a snapshot of the motor, servo and mode outputs together with the frame status. A
// request is registered on entry and its result is registered on exit, and a new request is
// taken in every cycle while the master side keeps up.
// The start byte, end byte and joystick deadband are written through the configuration
// channel, which is always ready and should only be used while the block is idle.
`include "assert_macros.svh"

module uart_command_frame_motor_servo_ctrl_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// rx_byte [7:0], joy_fwd [15:8], joy_turn [23:16], joy_pan [31:24], joy_tilt [39:32]
	input  logic [39:0] s_axis_tdata,
	// func [0]
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// motor_a_dir [1:0], motor_a_duty [9:2], motor_b_dir [11:10], motor_b_duty [19:12],
	// servo_x_pulse [27:20], servo_y_pulse [35:28], manual_on [36], remote_led [37],
	// preset_led [38], status [40:39], zero fill [47:41]
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import ucf_pkg::*;

	logic        valid_s1;
	logic [39:0] data_s1;
	logic        func_s1;
	logic        out_valid_q;
	ucf_result_t res_q;
	ucf_result_t res_n;
	ucf_cmd_t    cmd;
	ucf_drive_t  drive;
	logic [7:0]  start_q;
	logic [7:0]  end_q;
	logic [6:0]  deadband_q;
	logic        advance;
	logic        fire;
	logic        s_accept;

	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= START_RESET;
			end_q      <= END_RESET;
			deadband_q <= DEADBAND_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START:    start_q    <= cfg_data;
				REG_END:      end_q      <= cfg_data;
				REG_DEADBAND: deadband_q <= cfg_data[6:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			data_s1 <= s_axis_tdata;
			func_s1 <= s_axis_tuser[0];
		end
		if (fire) begin
			res_q <= res_n;
		end
	end

	ucf_frame_rx u_frame_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.func       (func_s1),
		.rx_byte    (data_s1[7:0]),
		.start_byte (start_q),
		.end_byte   (end_q),
		.cmd        (cmd)
	);

	ucf_mixer u_mixer (
		.joy_fwd  (data_s1[15:8]),
		.joy_turn (data_s1[23:16]),
		.deadband (deadband_q),
		.drive    (drive)
	);

	ucf_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.func     (func_s1),
		.cmd      (cmd),
		.drive    (drive),
		.joy_pan  (data_s1[31:24]),
		.joy_tilt (data_s1[39:32]),
		.res      (res_n)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, res_q.status, res_q.preset_led, res_q.remote_led,
		res_q.manual_on, res_q.servo_y_pulse, res_q.servo_x_pulse, res_q.motor_b_duty,
		res_q.motor_b_dir, res_q.motor_a_duty, res_q.motor_a_dir};

	`ASSERT_IMPLIES(a_mode_leds, clk, arst_n, m_axis_tvalid,
		res_q.manual_on != res_q.remote_led)
	`ASSERT_IMPLIES(a_bad_slot_led, clk, arst_n,
		m_axis_tvalid && res_q.status == ST_BAD_SLOT, res_q.preset_led)
	`ASSERT_IMPLIES(a_stop_duty, clk, arst_n,
		m_axis_tvalid && res_q.motor_a_dir == DIR_STOP, res_q.motor_a_duty == 8'd0)
	`ASSERT_NEXT(a_result_follows, clk, arst_n, fire, m_axis_tvalid)

endmodule
